[sv/utv_pkg.sv]
// Shared types and constants for the UTF-8 text validator.
package utv_pkg;

   localparam int CNT_W          = 11;
   localparam int LENGTH_CEILING = 1024;
   localparam int COUNT_TOP      = 2046;

   // Effective ceiling on the configured limit; keeps the count within CNT_W bits.
   localparam logic [CNT_W-1:0] LIMIT_CAP =
      CNT_W'((LENGTH_CEILING > COUNT_TOP) ? COUNT_TOP : LENGTH_CEILING);

   localparam logic [CNT_W-1:0] MAX_BYTES_RESET = CNT_W'(256);

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [2:0] REASON_OK        = 3'd0;
   localparam logic [2:0] REASON_EMPTY     = 3'd1;
   localparam logic [2:0] REASON_TOO_LONG  = 3'd2;
   localparam logic [2:0] REASON_CONTROL   = 3'd3;
   localparam logic [2:0] REASON_MALFORMED = 3'd4;

   typedef struct packed {
      logic       kind;
      logic [7:0] text_byte;
   } req_type;

   typedef struct packed {
      logic             valid_res;
      logic [2:0]       reason;
      logic [CNT_W-1:0] byte_count;
   } rsp_type;

endpackage

[sv/utv_scan.sv]
// Per-string scan state: byte counter, control and UTF-8 checks, verdict on end.
module utv_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  utv_pkg::req_type        item,
   input  logic [utv_pkg::CNT_W-1:0] max_bytes,
   output utv_pkg::rsp_type        verdict
);
   import utv_pkg::*;

   typedef enum logic [2:0] {
      LEAD_NONE = 3'd0,
      LEAD_E0   = 3'd1,
      LEAD_ED   = 3'd2,
      LEAD_F0   = 3'd3,
      LEAD_F4   = 3'd4
   } lead_type;

   logic [1:0]       pend_ff, pend_in;
   lead_type         lead_ff, lead_in;
   logic [CNT_W-1:0] seen_ff, seen_in;
   logic             ctrl_ff, ctrl_in;
   logic             mal_ff, mal_in;

   logic [CNT_W-1:0] limit;
   logic             mal_end;
   logic [2:0]       reason;
   logic [7:0]       b;
   logic             bad_second;
   logic             is_cont;

   assign limit = (max_bytes > LIMIT_CAP) ? LIMIT_CAP : max_bytes;
   assign b     = item.text_byte;

   // Verdict for an end item, first failing check wins
   always_comb begin
      mal_end = mal_ff | (pend_ff != 2'd0);
      priority if (seen_ff == '0) begin
         reason = REASON_EMPTY;
      end else if (seen_ff > limit) begin
         reason = REASON_TOO_LONG;
      end else if (ctrl_ff) begin
         reason = REASON_CONTROL;
      end else if (mal_end) begin
         reason = REASON_MALFORMED;
      end else begin
         reason = REASON_OK;
      end
      verdict.valid_res  = (reason == REASON_OK);
      verdict.reason     = reason;
      verdict.byte_count = seen_ff;
   end

   // Second-byte range limits after the special leads
   always_comb begin
      is_cont = (b[7:6] == 2'b10);
      unique case (lead_ff)
         LEAD_E0: bad_second = (b < 8'ha0);
         LEAD_ED: bad_second = (b > 8'h9f);
         LEAD_F0: bad_second = (b < 8'h90);
         LEAD_F4: bad_second = (b > 8'h8f);
         default: bad_second = 1'b0;
      endcase
   end

   always_comb begin
      pend_in = pend_ff;
      lead_in = lead_ff;
      seen_in = seen_ff;
      ctrl_in = ctrl_ff;
      mal_in  = mal_ff;
      if (step) begin
         if (item.kind == KIND_END) begin
            pend_in = 2'd0;
            lead_in = LEAD_NONE;
            seen_in = '0;
            ctrl_in = 1'b0;
            mal_in  = 1'b0;
         end else begin
            if (seen_ff <= limit) begin
               seen_in = seen_ff + CNT_W'(1);
            end
            if (b < 8'h20 || b == 8'h7f) begin
               ctrl_in = 1'b1;
            end
            if (pend_ff == 2'd0) begin
               priority if (b < 8'h80) begin
                  pend_in = 2'd0;
               end else if (b >= 8'hc2 && b <= 8'hdf) begin
                  pend_in = 2'd1;
                  lead_in = LEAD_NONE;
               end else if (b >= 8'he0 && b <= 8'hef) begin
                  pend_in = 2'd2;
                  lead_in = (b == 8'he0) ? LEAD_E0 : (b == 8'hed) ? LEAD_ED : LEAD_NONE;
               end else if (b >= 8'hf0 && b <= 8'hf4) begin
                  pend_in = 2'd3;
                  lead_in = (b == 8'hf0) ? LEAD_F0 : (b == 8'hf4) ? LEAD_F4 : LEAD_NONE;
               end else begin
                  mal_in  = 1'b1;
                  pend_in = 2'd0;
                  lead_in = LEAD_NONE;
               end
            end else if (!is_cont || bad_second) begin
               // fault drops the open sequence
               mal_in  = 1'b1;
               pend_in = 2'd0;
               lead_in = LEAD_NONE;
            end else begin
               lead_in = LEAD_NONE;
               pend_in = pend_ff - 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
         lead_ff <= LEAD_NONE;
         seen_ff <= '0;
         ctrl_ff <= 1'b0;
         mal_ff  <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         lead_ff <= lead_in;
         seen_ff <= seen_in;
         ctrl_ff <= ctrl_in;
         mal_ff  <= mal_in;
      end
   end

`ifndef SYNTHESIS
   a_lead_needs_open_seq: assert property (@(posedge clock) disable iff (reset)
      (pend_ff == 2'd0) |-> (lead_ff == LEAD_NONE))
      else $error("lead class set with no open sequence");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= LIMIT_CAP + CNT_W'(1))
      else $error("byte counter beyond saturation point");

   a_cleared_after_end: assert property (@(posedge clock) disable iff (reset)
      (step && item.kind == KIND_END) |=> (seen_ff == '0 && !ctrl_ff && !mal_ff))
      else $error("string state not cleared after end item");
`endif

endmodule

[sv/utv_rsp_reg.sv]
// Result register for the verdict channel.
module utv_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  utv_pkg::rsp_type load_data,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output utv_pkg::rsp_type rsp_payload
);
   import utv_pkg::*;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= load_data;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[sv/utf8_text_validator.sv]
// Top level of the UTF-8 text validator: request register, scan and result register.
//
// Usage:
//  - Requests arrive on req_* (valid/stall). Each request is either a text byte
//    (kind 0) or the end of the current string (kind 1). Bytes give no result;
//    every end request gives one verdict on rsp_* (valid/stall).
//  - The verdict carries valid_res, a reason code (ok, empty, too long, control
//    byte, malformed UTF-8; first failing check wins) and the saturating count.
//  - csr_* writes max_bytes, the length limit; csr_ready is always high. The
//    limit is capped at the build-time ceiling. Write it only while idle.
//  - Path: an end request is registered in the request register and, once it
//    advances, its verdict is loaded into the result register, which drives
//    rsp_valid.
//  - Throughput: one request per cycle while req_stall is low, set by the scan
//    between the request register and the result register.
//  - Stalls: a held verdict stays put while rsp_stall is high. Byte requests
//    keep flowing meanwhile; an end request waits in the request register,
//    and then req_stall goes high, until the result register frees up.
//  - Reset (synchronous, active high) empties both registers, clears the scan
//    state and sets max_bytes to 256.
module utf8_text_validator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  utv_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output utv_pkg::rsp_type          rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [utv_pkg::CNT_W-1:0] csr_data
);
   import utv_pkg::*;

   logic             req_valid_ff, req_valid_in;
   req_type          req_ff;
   logic [CNT_W-1:0] max_bytes_ff;

   logic             rsp_free;
   logic             advance;
   logic             is_end;
   rsp_type          verdict;

   // Config register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_BYTES_RESET;
      end else if (csr_valid && csr_ready) begin
         max_bytes_ff <= csr_data;
      end
   end

   // Request register advances unless an end request meets a held verdict
   assign is_end    = (req_ff.kind == KIND_END);
   assign rsp_free  = !rsp_valid || !rsp_stall;
   assign advance   = req_valid_ff && (!is_end || rsp_free);
   assign req_stall = req_valid_ff && !advance;

   assign req_valid_in = req_stall ? req_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_ff <= req_payload;
      end
   end

   utv_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (req_ff),
      .max_bytes (max_bytes_ff),
      .verdict   (verdict)
   );

   utv_rsp_reg u_rsp_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (advance && is_end),
      .load_data   (verdict),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   a_ok_matches_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.valid_res == (rsp_payload.reason == REASON_OK)))
      else $error("valid_res disagrees with reason code");

   a_empty_iff_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.byte_count == '0) ==
                     (rsp_payload.reason == REASON_EMPTY)))
      else $error("empty reason disagrees with byte count");

   a_stall_only_on_end: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (req_valid_ff && is_end && rsp_valid && rsp_stall))
      else $error("request stalled without a held verdict");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_payload) && rsp_valid))
      else $error("held verdict overwritten");
`endif

endmodule

[sim/utf8_text_validator_tb.sv]
// Self-checking testbench for the UTF-8 text validator: directed, limit and random strings.
module utf8_text_validator_tb;
   import utv_pkg::*;

   // Scan state for a string in flight: which second-byte window applies next.
   typedef enum logic [2:0] {
      LEAD_PLAIN,
      LEAD_E0,
      LEAD_ED,
      LEAD_F0,
      LEAD_F4
   } lead_type;

   // Every input is known from time zero; reset is held from the first edge.
   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_valid   = 1'b0;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_data    = '0;

   // Predicted verdicts, oldest first, one per accepted end request.
   rsp_type pending_verdicts[$];
   int      mismatch_count = 0;

   // Predictor copy of the limit register and of the per-string scan state.
   logic [CNT_W-1:0] limit_reg   = MAX_BYTES_RESET;
   logic [1:0]       cont_left   = '0;
   lead_type         lead        = LEAD_PLAIN;
   logic [CNT_W-1:0] seen_count  = '0;
   logic             ctl_seen    = 1'b0;
   logic             bad_seen    = 1'b0;

   // Bytes of the string being built for the next send.
   logic [7:0] text_buf[$];

   // Calm stretches: no gaps on the request side, no stalls on the result side.
   logic       calm       = 1'b0;
   logic [7:0] calm_timer = '0;
   int         stall_left = 0;

   utf8_text_validator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Limit in force: the register, capped so the count stays in CNT_W bits.
   function automatic logic [CNT_W-1:0] limit_in_force();
      return (limit_reg > LIMIT_CAP) ? LIMIT_CAP : limit_reg;
   endfunction

   // A UTF-8 fault drops the open sequence; later bytes are read as leads.
   function automatic void flag_malformed();
      bad_seen  = 1'b1;
      cont_left = '0;
      lead      = LEAD_PLAIN;
   endfunction

   function automatic void clear_string();
      cont_left  = '0;
      lead       = LEAD_PLAIN;
      seen_count = '0;
      ctl_seen   = 1'b0;
      bad_seen   = 1'b0;
   endfunction

   function automatic void scan_byte(input logic [7:0] b);
      // Counter stops once it has passed the limit, i.e. saturates at limit + 1.
      if (seen_count <= limit_in_force()) seen_count = seen_count + CNT_W'(1);
      if (b < 8'h20 || b == 8'h7F) ctl_seen = 1'b1;

      if (cont_left == 2'd0) begin
         if (b < 8'h80) return;
         if (b >= 8'hC2 && b <= 8'hDF) begin
            cont_left = 2'd1;
            lead      = LEAD_PLAIN;
         end else if (b >= 8'hE0 && b <= 8'hEF) begin
            cont_left = 2'd2;
            if (b == 8'hE0) lead = LEAD_E0;
            else if (b == 8'hED) lead = LEAD_ED;
            else lead = LEAD_PLAIN;
         end else if (b >= 8'hF0 && b <= 8'hF4) begin
            cont_left = 2'd3;
            if (b == 8'hF0) lead = LEAD_F0;
            else if (b == 8'hF4) lead = LEAD_F4;
            else lead = LEAD_PLAIN;
         end else begin
            // C0, C1, F5-FF and stray continuation bytes
            flag_malformed();
         end
      end else if (b[7:6] != 2'b10) begin
         flag_malformed();
      end else if ((lead == LEAD_E0 && b < 8'hA0) ||
                   (lead == LEAD_ED && b > 8'h9F) ||
                   (lead == LEAD_F0 && b < 8'h90) ||
                   (lead == LEAD_F4 && b > 8'h8F)) begin
         // overlong, surrogate or beyond U+10FFFF
         flag_malformed();
      end else begin
         lead      = LEAD_PLAIN;
         cont_left = cont_left - 2'd1;
      end
   endfunction

   // Applies one accepted request; an end request yields the expected verdict.
   function automatic void predict_verdict(input req_type r);
      rsp_type v;
      if (r.kind == KIND_BYTE) begin
         scan_byte(r.text_byte);
         return;
      end
      // A sequence still open at the end item is malformed.
      if (cont_left != 2'd0) bad_seen = 1'b1;
      // Priority: empty, too long, control byte, malformed.
      if (seen_count == '0) v.reason = REASON_EMPTY;
      else if (seen_count > limit_in_force()) v.reason = REASON_TOO_LONG;
      else if (ctl_seen) v.reason = REASON_CONTROL;
      else if (bad_seen) v.reason = REASON_MALFORMED;
      else v.reason = REASON_OK;
      v.valid_res  = (v.reason == REASON_OK);
      v.byte_count = seen_count;
      pending_verdicts.insert(pending_verdicts.size(), v);
      clear_string();
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Mostly no gap or a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Sends one request. valid stays high into the next call so that
   // back-to-back requests go through without a bubble.
   task automatic send_request(input logic k, input logic [7:0] b);
      req_type r;
      int      gap;
      r.kind      = k;
      r.text_byte = b;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      predict_verdict(r);
   endtask

   // Sends the buffered bytes and then the end request, whose byte is junk.
   task automatic send_text();
      foreach (text_buf[i]) send_request(KIND_BYTE, text_buf[i]);
      send_request(KIND_END, 8'($urandom_range(0, 255)));
   endtask

   // Holds off the sender until every verdict is in, then lets the scan settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CNT_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      limit_reg = v;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // String builders
   // ---------------------------------------------------------------------

   // Appends one byte to the string being built.
   function automatic void add_byte(input logic [7:0] b);
      text_buf.insert(text_buf.size(), b);
   endfunction

   function automatic void fill_printable(input int n);
      text_buf.delete();
      repeat (n) add_byte(8'($urandom_range(8'h20, 8'h7E)));
   endfunction

   function automatic logic [7:0] any_cont();
      return 8'($urandom_range(8'h80, 8'hBF));
   endfunction

   // One well-formed character with random content.
   function automatic void add_char();
      logic [7:0] ld;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: add_byte(8'($urandom_range(8'h20, 8'h7E)));
         4, 5: begin
            add_byte(8'($urandom_range(8'hC2, 8'hDF)));
            add_byte(any_cont());
         end
         6, 7: begin
            ld = 8'($urandom_range(8'hE0, 8'hEF));
            add_byte(ld);
            if (ld == 8'hE0) add_byte(8'($urandom_range(8'hA0, 8'hBF)));
            else if (ld == 8'hED) add_byte(8'($urandom_range(8'h80, 8'h9F)));
            else add_byte(any_cont());
            add_byte(any_cont());
         end
         default: begin
            ld = 8'($urandom_range(8'hF0, 8'hF4));
            add_byte(ld);
            if (ld == 8'hF0) add_byte(8'($urandom_range(8'h90, 8'hBF)));
            else if (ld == 8'hF4) add_byte(8'($urandom_range(8'h80, 8'h8F)));
            else add_byte(any_cont());
            add_byte(any_cont());
            add_byte(any_cont());
         end
      endcase
   endfunction

   // One broken or otherwise unwelcome fragment.
   function automatic void add_fault();
      case ($urandom_range(0, 5))
         0: add_byte(8'($urandom_range(0, 255)));
         1: add_byte(($urandom_range(0, 4) == 0) ? 8'h7F : 8'($urandom_range(0, 8'h1F)));
         // lead with its sequence cut short
         2: add_byte(8'($urandom_range(8'hC2, 8'hF4)));
         // lead bytes that never start a sequence
         3: add_byte(($urandom_range(0, 2) == 0) ? 8'($urandom_range(8'hC0, 8'hC1))
                                                 : 8'($urandom_range(8'hF5, 8'hFF)));
         // second byte just outside its window
         4: begin
            case ($urandom_range(0, 3))
               0: begin add_byte(8'hE0); add_byte(8'h9F); end
               1: begin add_byte(8'hED); add_byte(8'hA0); end
               2: begin add_byte(8'hF0); add_byte(8'h8F); end
               default: begin add_byte(8'hF4); add_byte(8'h90); end
            endcase
            add_byte(any_cont());
         end
         default: add_byte(any_cont());
      endcase
   endfunction

   // Mostly clean text; the rest mixes faults in among good characters.
   function automatic void build_text();
      bit clean;
      int nchars;
      text_buf.delete();
      clean  = ($urandom_range(0, 3) != 0);
      nchars = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 8);
      repeat (nchars) begin
         if (!clean && $urandom_range(0, 2) == 0) add_fault();
         else add_char();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes and every verdict but too long, at the reset limit.
   task automatic check_special_cases();
      text_buf.delete();                                   send_text(); // empty
      text_buf = '{8'h41};                                 send_text();
      text_buf = '{8'h00};                                 send_text(); // control
      text_buf = '{8'h7F, 8'hFF};                          send_text(); // control beats malformed
      text_buf = '{8'hE0, 8'h9F, 8'h80};                   send_text(); // overlong
      text_buf = '{8'hED, 8'hA0, 8'h80};                   send_text(); // surrogate
      text_buf = '{8'hF0, 8'h8F};                          send_text();
      text_buf = '{8'hF4, 8'h90};                          send_text(); // above U+10FFFF
      text_buf = '{8'hC3};                                 send_text(); // left open
      text_buf = '{8'hF0, 8'h90, 8'h80, 8'h80};            send_text(); // good 4-byte
   endtask

   // Length boundaries across the limit range, including out-of-range settings.
   task automatic check_length_limits();
      wait_idle();
      write_limit(CNT_W'(1));
      fill_printable(1); send_text();
      fill_printable(2); send_text();
      fill_printable(5); send_text();                      // count saturates at 2
      wait_idle();
      write_limit(CNT_W'(0));                              // rejects anything non-empty
      fill_printable(1); send_text();
      text_buf.delete(); send_text();
      wait_idle();
      write_limit(CNT_W'(3));
      text_buf = '{8'h41, 8'h01, 8'h42, 8'h43, 8'hE0};     send_text(); // too long wins
      text_buf = '{8'h41, 8'h01, 8'hC3};                   send_text(); // control wins
      wait_idle();
      write_limit(CNT_W'(40));
      fill_printable(40); send_text();
      fill_printable(41); send_text();
      wait_idle();
      write_limit('1);                                     // capped to the ceiling
      fill_printable(20); send_text();
      wait_idle();
      write_limit(MAX_BYTES_RESET);
   endtask

   // Random strings under a handful of limits; now and then the sender waits
   // until the block has drained completely.
   task automatic check_random_text();
      int sent;
      int phase_items;
      sent        = 0;
      phase_items = 0;
      wait_idle();
      write_limit(CNT_W'($urandom_range(4, 16)));
      while (sent < 300) begin
         if (phase_items >= 90) begin
            wait_idle();
            case ($urandom_range(0, 4))
               0: write_limit(CNT_W'($urandom_range(1, 12)));
               1: write_limit(CNT_W'($urandom_range(13, 40)));
               2: write_limit(MAX_BYTES_RESET);
               3: write_limit(CNT_W'(LENGTH_CEILING));
               default: write_limit('1);
            endcase
            phase_items = 0;
         end
         build_text();
         sent        += text_buf.size() + 1;
         phase_items += text_buf.size() + 1;
         send_text();
         if ($urandom_range(0, 11) == 0) wait_idle();
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stalls and the verdict check
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      calm_timer <= calm_timer + 8'd1;
      if (calm_timer == 8'hFF) calm <= ($urandom_range(0, 3) == 0);
   end

   always @(posedge clock) begin : verdict_check
      rsp_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_verdicts.size() == 0) begin
               $display("%0t: verdict with none expected: %p", $time, rsp_payload);
               mismatch_count++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_payload.valid_res !== want.valid_res) begin
                  $display("%0t: valid_res expected %0b got %0b",
                           $time, want.valid_res, rsp_payload.valid_res);
                  mismatch_count++;
               end
               if (rsp_payload.reason !== want.reason) begin
                  $display("%0t: reason expected %0d got %0d",
                           $time, want.reason, rsp_payload.reason);
                  mismatch_count++;
               end
               if (rsp_payload.byte_count !== want.byte_count) begin
                  $display("%0t: byte_count expected %0d got %0d",
                           $time, want.byte_count, rsp_payload.byte_count);
                  mismatch_count++;
               end
            end
         end
         // Stall in segments: each segment is on or off for a random span.
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
         end else begin
            rsp_stall  <= !calm && ($urandom_range(0, 1) == 1);
            stall_left <= pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence and run control
   // ---------------------------------------------------------------------

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_special_cases();
      check_length_limits();
      check_random_text();
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #5000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
